>>> design/ebalu_pkg.sv
`default_nettype none

package ebalu_pkg;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_XOR   = 5'd5,
    OP_OR    = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_DAA   = 5'd10,
    OP_CPL   = 5'd11,
    OP_SCF   = 5'd12,
    OP_CCF   = 5'd13,
    OP_RLCA  = 5'd14,
    OP_RRCA  = 5'd15,
    OP_RLA   = 5'd16,
    OP_RRA   = 5'd17,
    OP_ADD16 = 5'd18
  } op_e;

  // flag byte masks, S Z Y H X PV N C from bit 7 down
  localparam logic [7:0] FL_S  = 8'h80;
  localparam logic [7:0] FL_Z  = 8'h40;
  localparam logic [7:0] FL_Y  = 8'h20;
  localparam logic [7:0] FL_H  = 8'h10;
  localparam logic [7:0] FL_X  = 8'h08;
  localparam logic [7:0] FL_PV = 8'h04;
  localparam logic [7:0] FL_N  = 8'h02;
  localparam logic [7:0] FL_C  = 8'h01;

  localparam int unsigned FB_H = 4;
  localparam int unsigned FB_N = 1;
  localparam int unsigned FB_C = 0;

  localparam logic [7:0] DAA_LIMIT    = 8'h99;
  localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
  localparam logic [3:0] DIGIT_MAX    = 4'd9;
  localparam logic [3:0] DAS_LO_LIMIT = 4'd5;
  localparam logic [7:0] INC_OVF      = 8'h80;
  localparam logic [7:0] DEC_OVF      = 8'h7f;

  typedef struct packed {
    logic [4:0]  operation;
    logic [7:0]  acc;
    logic [7:0]  operand;
    logic [7:0]  flags_in;
    logic [15:0] wide_left;
    logic [15:0] wide_right;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  result;
    logic [15:0] wide_result;
    logic [7:0]  flags_out;
  } out_item_t;

  function automatic logic [7:0] szxy_of(logic [7:0] v);
    return {v[7], (v == 8'h00), v[5], 1'b0, v[3], 3'b000};
  endfunction

  function automatic logic [7:0] parity_of(logic [7:0] v);
    return {5'b00000, ~(^v), 2'b00};
  endfunction

endpackage

`default_nettype wire

>>> design/ebalu_core.sv
`default_nettype none

module ebalu_core (
  input  wire ebalu_pkg::in_item_t   item_i,
  output ebalu_pkg::out_item_t       item_o
);

  logic [7:0]  a, v, f;
  logic        cy;
  logic        sub_c, cin_c;
  logic [8:0]  sum9, ci9;
  logic [7:0]  arith_f;
  logic [3:0]  lo;
  logic        daa_c, daa_h;
  logic [7:0]  diff;
  logic [7:0]  daa_r;
  logic [16:0] sum17;
  logic [15:0] ci16;
  logic [7:0]  r, fo;
  logic [15:0] w;
  logic [7:0]  keep_nhc;

  assign a  = item_i.acc;
  assign v  = item_i.operand;
  assign f  = item_i.flags_in;
  assign cy = f[ebalu_pkg::FB_C];

  // shared 8-bit adder for add, adc, sub, sbc and cp
  assign sub_c = (item_i.operation == ebalu_pkg::OP_SUB) ||
                 (item_i.operation == ebalu_pkg::OP_SBC) ||
                 (item_i.operation == ebalu_pkg::OP_CP);
  assign cin_c = cy && ((item_i.operation == ebalu_pkg::OP_ADC) ||
                        (item_i.operation == ebalu_pkg::OP_SBC));
  assign sum9  = sub_c ? ({1'b0, a} - {1'b0, v} - {8'h00, cin_c})
                       : ({1'b0, a} + {1'b0, v} + {8'h00, cin_c});
  assign ci9   = sum9 ^ {1'b0, a} ^ {1'b0, v};
  assign arith_f = ebalu_pkg::szxy_of(sum9[7:0])
                 | (ci9[4] ? ebalu_pkg::FL_H : 8'h00)
                 | ((ci9[7] ^ ci9[8]) ? ebalu_pkg::FL_PV : 8'h00)
                 | (ci9[8] ? ebalu_pkg::FL_C : 8'h00)
                 | (sub_c ? ebalu_pkg::FL_N : 8'h00);

  // decimal adjust
  assign lo    = a[3:0];
  assign daa_c = cy || (a > ebalu_pkg::DAA_LIMIT);
  assign diff  = (daa_c ? ebalu_pkg::DAA_HI_ADJ : 8'h00)
               + ((f[ebalu_pkg::FB_H] || (lo > ebalu_pkg::DIGIT_MAX))
                  ? ebalu_pkg::DAA_LO_ADJ : 8'h00);
  assign daa_h = f[ebalu_pkg::FB_N] ? (f[ebalu_pkg::FB_H] && !(lo > ebalu_pkg::DAS_LO_LIMIT))
                                    : (lo > ebalu_pkg::DIGIT_MAX);
  assign daa_r = f[ebalu_pkg::FB_N] ? (a - diff) : (a + diff);

  assign sum17 = {1'b0, item_i.wide_left} + {1'b0, item_i.wide_right};
  assign ci16  = sum17[15:0] ^ item_i.wide_left ^ item_i.wide_right;

  assign keep_nhc = f & ~(ebalu_pkg::FL_N | ebalu_pkg::FL_H | ebalu_pkg::FL_C);

  always_comb begin
    r  = a;
    w  = 16'h0000;
    fo = f;
    case (ebalu_pkg::op_e'(item_i.operation))
      ebalu_pkg::OP_ADD, ebalu_pkg::OP_ADC, ebalu_pkg::OP_SUB, ebalu_pkg::OP_SBC: begin
        r  = sum9[7:0];
        fo = arith_f;
      end
      ebalu_pkg::OP_AND: begin
        r  = a & v;
        fo = ebalu_pkg::szxy_of(a & v) | ebalu_pkg::parity_of(a & v) | ebalu_pkg::FL_H;
      end
      ebalu_pkg::OP_XOR: begin
        r  = a ^ v;
        fo = ebalu_pkg::szxy_of(a ^ v) | ebalu_pkg::parity_of(a ^ v);
      end
      ebalu_pkg::OP_OR: begin
        r  = a | v;
        fo = ebalu_pkg::szxy_of(a | v) | ebalu_pkg::parity_of(a | v);
      end
      ebalu_pkg::OP_CP: begin
        // x and y come from the operand, not the difference
        fo = (arith_f & ~(ebalu_pkg::FL_Y | ebalu_pkg::FL_X))
           | (v & (ebalu_pkg::FL_Y | ebalu_pkg::FL_X));
      end
      ebalu_pkg::OP_INC: begin
        r  = v + 8'h01;
        fo = (f & ebalu_pkg::FL_C) | ebalu_pkg::szxy_of(v + 8'h01)
           | (((v + 8'h01) == ebalu_pkg::INC_OVF) ? ebalu_pkg::FL_PV : 8'h00)
           | (((v[3:0] + 4'h1) == 4'h0) ? ebalu_pkg::FL_H : 8'h00);
      end
      ebalu_pkg::OP_DEC: begin
        r  = v - 8'h01;
        fo = (f & ebalu_pkg::FL_C) | ebalu_pkg::szxy_of(v - 8'h01) | ebalu_pkg::FL_N
           | (((v - 8'h01) == ebalu_pkg::DEC_OVF) ? ebalu_pkg::FL_PV : 8'h00)
           | (((v[3:0] - 4'h1) == 4'hf) ? ebalu_pkg::FL_H : 8'h00);
      end
      ebalu_pkg::OP_DAA: begin
        r  = daa_r;
        fo = ebalu_pkg::szxy_of(daa_r) | ebalu_pkg::parity_of(daa_r)
           | (f & ebalu_pkg::FL_N)
           | (daa_c ? ebalu_pkg::FL_C : 8'h00)
           | (daa_h ? ebalu_pkg::FL_H : 8'h00);
      end
      ebalu_pkg::OP_CPL: begin
        r  = ~a;
        fo = f | ebalu_pkg::FL_H | ebalu_pkg::FL_N;
      end
      ebalu_pkg::OP_SCF: begin
        fo = (f & (ebalu_pkg::FL_S | ebalu_pkg::FL_Z | ebalu_pkg::FL_PV))
           | ebalu_pkg::FL_C | (a & (ebalu_pkg::FL_Y | ebalu_pkg::FL_X));
      end
      ebalu_pkg::OP_CCF: begin
        fo = (f & (ebalu_pkg::FL_S | ebalu_pkg::FL_Z | ebalu_pkg::FL_PV))
           | (a & (ebalu_pkg::FL_Y | ebalu_pkg::FL_X))
           | (cy ? ebalu_pkg::FL_H : ebalu_pkg::FL_C);
      end
      ebalu_pkg::OP_RLCA: begin
        r  = {a[6:0], a[7]};
        fo = keep_nhc | {7'b0000000, a[7]};
      end
      ebalu_pkg::OP_RLA: begin
        r  = {a[6:0], cy};
        fo = keep_nhc | {7'b0000000, a[7]};
      end
      ebalu_pkg::OP_RRCA: begin
        r  = {a[0], a[7:1]};
        fo = keep_nhc | {7'b0000000, a[0]};
      end
      ebalu_pkg::OP_RRA: begin
        r  = {cy, a[7:1]};
        fo = keep_nhc | {7'b0000000, a[0]};
      end
      ebalu_pkg::OP_ADD16: begin
        // half carry is the carry into bit 11, out of bit 10
        w  = sum17[15:0];
        fo = keep_nhc | (sum17[16] ? ebalu_pkg::FL_C : 8'h00)
           | (ci16[11] ? ebalu_pkg::FL_H : 8'h00);
      end
      default: begin
        r  = a;
        w  = 16'h0000;
        fo = f;
      end
    endcase
  end

  assign item_o.result      = r;
  assign item_o.wide_result = w;
  assign item_o.flags_out   = fo;

endmodule

`default_nettype wire

>>> design/eight_bit_alu_with_flags_unit.sv
`default_nettype none

// channel | direction | handshake            | payload
// in      | input     | in_valid_i, in_stall_o   | in_item_i  (ebalu_pkg::in_item_t)
// out     | output    | out_valid_o, out_stall_i | out_item_o (ebalu_pkg::out_item_t)
//
// one item per clock sustained while out is not stalled; input register then
// result register, with the alu logic between them.
// reset clears only the two valid flags; payload registers are not reset.
// a stalled result holds in the result register while the input register
// keeps one more item; in_stall_o rises only when both are full and out stalls.

module eight_bit_alu_with_flags_unit (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  wire ebalu_pkg::in_item_t   in_item_i,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output ebalu_pkg::out_item_t       out_item_o
);

  logic                 s1_valid_q, s1_valid_d;
  ebalu_pkg::in_item_t  s1_item_q;
  logic                 out_valid_q, out_valid_d;
  ebalu_pkg::out_item_t out_item_q;
  ebalu_pkg::out_item_t alu_item;
  logic                 adv2, adv1;

  assign adv2 = !out_valid_q || !out_stall_i;
  assign adv1 = !s1_valid_q || adv2;

  assign in_stall_o = !adv1;

  assign s1_valid_d  = adv1 ? in_valid_i : s1_valid_q;
  assign out_valid_d = adv2 ? s1_valid_q : out_valid_q;

  ebalu_core u_core (
    .item_i (s1_item_q),
    .item_o (alu_item)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
    if (adv2 && s1_valid_q) begin
      out_item_q <= alu_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // an accepted item always lands in the input register
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> s1_valid_q)
    else $error("accepted item lost at input register");

  // a held item in the input register must not change
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv2 |=> s1_valid_q && $stable(s1_item_q))
    else $error("input register changed while blocked");

  // a moving item reaches the result register next cycle
  a_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && adv2 |=> out_valid_o)
    else $error("item dropped between stages");

  // back pressure only when both stages are full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with room available");

endmodule

`default_nettype wire

>>> tb/eight_bit_alu_with_flags_unit_tb.sv
module eight_bit_alu_with_flags_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ebalu_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 1750;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // codes above the last operation do nothing
  localparam logic [4:0]  OP_UNUSED_LOW  = 5'd19;
  localparam logic [4:0]  OP_UNUSED_TOP  = 5'd31;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_stall;
  in_item_t  in_item     = '0;
  logic      out_valid;
  logic      out_stall   = 1'b0;
  out_item_t out_item;

  out_item_t   pending_results[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatches = 0;
  int unsigned idle_count = 0;
  bit          tx_quiet   = 1'b0;

  eight_bit_alu_with_flags_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [7:0] sz_xy_flags(logic [7:0] v);
    logic [7:0] fl;
    fl = v & (FL_S | FL_Y | FL_X);
    if (v == 8'h00) fl |= FL_Z;
    return fl;
  endfunction

  function automatic logic [7:0] parity_flag(logic [7:0] v);
    return (^v) ? 8'h00 : FL_PV;
  endfunction

  // returns {flags, result}
  function automatic logic [15:0] add_sub8(logic [7:0] a, logic [7:0] b, logic cin,
                                           logic minus);
    logic [8:0] sum;
    logic [8:0] cv;
    logic [7:0] fl;
    if (minus) sum = {1'b0, a} - {1'b0, b} - {8'b0, cin};
    else sum = {1'b0, a} + {1'b0, b} + {8'b0, cin};
    cv = sum ^ {1'b0, a} ^ {1'b0, b};
    fl = sz_xy_flags(sum[7:0]);
    if (cv[4]) fl |= FL_H;
    if (cv[7] ^ cv[8]) fl |= FL_PV;
    if (cv[8]) fl |= FL_C;
    if (minus) fl |= FL_N;
    return {fl, sum[7:0]};
  endfunction

  function automatic out_item_t alu_predict(in_item_t it);
    out_item_t   o;
    logic [7:0]  a;
    logic [7:0]  v;
    logic [7:0]  f;
    logic [7:0]  fo;
    logic [7:0]  r;
    logic [7:0]  diff;
    logic [3:0]  lo;
    logic [16:0] sum16;
    logic [15:0] w;
    logic        sbit;
    a  = it.acc;
    v  = it.operand;
    f  = it.flags_in;
    r  = a;
    fo = f;
    w  = '0;
    case (it.operation)
      OP_ADD: {fo, r} = add_sub8(a, v, 1'b0, 1'b0);
      OP_ADC: {fo, r} = add_sub8(a, v, f[FB_C], 1'b0);
      OP_SUB: {fo, r} = add_sub8(a, v, 1'b0, 1'b1);
      OP_SBC: {fo, r} = add_sub8(a, v, f[FB_C], 1'b1);
      OP_AND: begin
        r  = a & v;
        fo = sz_xy_flags(r) | parity_flag(r) | FL_H;
      end
      OP_XOR: begin
        r  = a ^ v;
        fo = sz_xy_flags(r) | parity_flag(r);
      end
      OP_OR: begin
        r  = a | v;
        fo = sz_xy_flags(r) | parity_flag(r);
      end
      OP_CP: begin
        {fo, r} = add_sub8(a, v, 1'b0, 1'b1);
        // compare takes x and y from the operand, not the difference
        fo = (fo & ~(FL_Y | FL_X)) | (v & (FL_Y | FL_X));
        r  = a;
      end
      OP_INC: begin
        r  = v + 8'd1;
        fo = (f & FL_C) | sz_xy_flags(r);
        if (r == INC_OVF) fo |= FL_PV;
        if (r[3:0] == 4'h0) fo |= FL_H;
      end
      OP_DEC: begin
        r  = v - 8'd1;
        fo = (f & FL_C) | sz_xy_flags(r) | FL_N;
        if (r == DEC_OVF) fo |= FL_PV;
        if (r[3:0] == 4'hf) fo |= FL_H;
      end
      OP_DAA: begin
        lo   = a[3:0];
        diff = 8'h00;
        fo   = f & (FL_N | FL_C | FL_H);
        if (f[FB_C] || a > DAA_LIMIT) begin
          diff += DAA_HI_ADJ;
          fo |= FL_C;
        end
        if (f[FB_H] || lo > DIGIT_MAX) diff += DAA_LO_ADJ;
        if (f[FB_N]) begin
          if (lo > DAS_LO_LIMIT) fo &= ~FL_H;
          r = a - diff;
        end else begin
          fo &= ~FL_H;
          if (lo > DIGIT_MAX) fo |= FL_H;
          r = a + diff;
        end
        fo = (fo & (FL_N | FL_C | FL_H)) | sz_xy_flags(r) | parity_flag(r);
      end
      OP_CPL: begin
        r  = ~a;
        fo = f | FL_H | FL_N;
      end
      OP_SCF: fo = (f & (FL_S | FL_Z | FL_PV)) | FL_C | (a & (FL_Y | FL_X));
      OP_CCF: begin
        fo = (f & (FL_S | FL_Z | FL_PV)) | (a & (FL_Y | FL_X));
        fo |= f[FB_C] ? FL_H : FL_C;
      end
      OP_RLCA, OP_RLA: begin
        sbit = (it.operation == OP_RLCA) ? a[7] : f[FB_C];
        r    = {a[6:0], sbit};
        fo   = (f & ~(FL_N | FL_H | FL_C)) | {7'b0, a[7]};
      end
      OP_RRCA, OP_RRA: begin
        sbit = (it.operation == OP_RRCA) ? a[0] : f[FB_C];
        r    = {sbit, a[7:1]};
        fo   = (f & ~(FL_N | FL_H | FL_C)) | {7'b0, a[0]};
      end
      OP_ADD16: begin
        sum16 = {1'b0, it.wide_left} + {1'b0, it.wide_right};
        w     = sum16[15:0];
        fo    = f & ~(FL_N | FL_C | FL_H);
        if (sum16[16]) fo |= FL_C;
        if (w[11] ^ it.wide_left[11] ^ it.wide_right[11]) fo |= FL_H;
      end
      default: ;
    endcase
    o.result      = r;
    o.wide_result = w;
    o.flags_out   = fo;
    return o;
  endfunction

  task automatic note_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic int unsigned idle_cycles(bit quiet);
    if (quiet || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 18);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h7f;
      3: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    if ($urandom_range(0, 11) == 0)
      it.operation = 5'($urandom_range(OP_UNUSED_LOW, OP_UNUSED_TOP));
    else
      it.operation = 5'($urandom_range(OP_ADD, OP_ADD16));
    it.acc        = pick_byte();
    it.operand    = pick_byte();
    it.flags_in   = 8'($urandom);
    it.wide_left  = ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom);
    it.wide_right = ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom);
    return it;
  endfunction

  task automatic add_case(input logic [4:0] op, input logic [7:0] a, input logic [7:0] v,
                          input logic [7:0] f, input logic [15:0] wl, input logic [15:0] wr,
                          input bit typed, input logic [7:0] r, input logic [15:0] w,
                          input logic [7:0] fo);
    stim_row_t row;
    row.stim       = '{operation: op, acc: a, operand: v, flags_in: f,
                       wide_left: wl, wide_right: wr};
    row.typed      = typed;
    row.want       = '{result: r, wide_result: w, flags_out: fo};
    directed_rows.push_back(row);
  endtask

  task automatic offer_item(input in_item_t stim, input bit typed, input out_item_t want);
    int unsigned gap;
    gap = idle_cycles(tx_quiet);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= stim;
    do @(posedge clk_i); while (in_stall);
    pending_results.push_back(typed ? want : alu_predict(stim));
  endtask

  // result checker
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_mismatch("item with nothing pending", {8'h00, out_item.result}, 16'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_item.result !== want.result)
          note_mismatch("result", {8'h00, out_item.result}, {8'h00, want.result});
        if (out_item.wide_result !== want.wide_result)
          note_mismatch("wide_result", out_item.wide_result, want.wide_result);
        if (out_item.flags_out !== want.flags_out)
          note_mismatch("flags_out", {8'h00, out_item.flags_out}, {8'h00, want.flags_out});
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
    end
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off so the block backs up
  initial begin : result_sink
    int unsigned wait_n;
    int unsigned taken;
    bit          rx_quiet;
    taken    = 0;
    rx_quiet = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (taken % 150 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      if (taken % 700 == 350) wait_n = HOLD_CYCLES;
      else wait_n = idle_cycles(rx_quiet);
      if (wait_n != 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
      taken++;
    end
  end

  initial begin
    add_case(OP_ADD, 8'hff, 8'h01, 8'h00, 16'hffff, 16'hffff, 1'b1, 8'h00, 16'h0000, 8'h51);
    add_case(OP_ADD, 8'h7f, 8'h01, 8'h00, 16'h0000, 16'h0000, 1'b1, 8'h80, 16'h0000, 8'h94);
    add_case(OP_ADC, 8'h00, 8'h00, 8'hff, 16'h0000, 16'h0000, 1'b1, 8'h01, 16'h0000, 8'h00);
    add_case(OP_SUB, 8'h00, 8'h01, 8'h00, 16'h0000, 16'h0000, 1'b1, 8'hff, 16'h0000, 8'hbb);
    add_case(OP_SBC, 8'h80, 8'h00, 8'h01, 16'h0000, 16'h0000, 1'b1, 8'h7f, 16'h0000, 8'h3e);
    add_case(OP_AND, 8'hff, 8'hff, 8'h00, 16'h0000, 16'h0000, 1'b1, 8'hff, 16'h0000, 8'hbc);
    add_case(OP_XOR, 8'h5a, 8'h5a, 8'hff, 16'h0000, 16'h0000, 1'b1, 8'h00, 16'h0000, 8'h44);
    add_case(OP_OR,  8'h00, 8'h00, 8'hff, 16'h0000, 16'h0000, 1'b1, 8'h00, 16'h0000, 8'h44);
    add_case(OP_CP,  8'h10, 8'h28, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_case(OP_INC, 8'h00, 8'hff, 8'hff, 16'h0000, 16'h0000, 1'b1, 8'h00, 16'h0000, 8'h51);
    add_case(OP_INC, 8'h00, 8'h7f, 8'h00, 16'h0000, 16'h0000, 1'b1, 8'h80, 16'h0000, 8'h94);
    add_case(OP_DEC, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1, 8'hff, 16'h0000, 8'hba);
    add_case(OP_DEC, 8'h00, 8'h80, 8'h01, 16'h0000, 16'h0000, 1'b1, 8'h7f, 16'h0000, 8'h3f);
    add_case(OP_DAA, 8'h9a, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_case(OP_DAA, 8'h00, 8'h00, 8'h13, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_case(OP_CPL, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1, 8'hff, 16'h0000, 8'h12);
    add_case(OP_SCF, 8'hff, 8'h00, 8'hff, 16'h0000, 16'h0000, 1'b1, 8'hff, 16'h0000, 8'hed);
    add_case(OP_CCF, 8'h00, 8'h00, 8'h01, 16'h0000, 16'h0000, 1'b1, 8'h00, 16'h0000, 8'h10);
    add_case(OP_RLCA, 8'h80, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1, 8'h01, 16'h0000, 8'h01);
    add_case(OP_RRCA, 8'h01, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1, 8'h80, 16'h0000, 8'h01);
    add_case(OP_RLA, 8'h00, 8'h00, 8'h01, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_case(OP_RRA, 8'hff, 8'h00, 8'hfe, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_case(OP_ADD16, 8'h33, 8'h00, 8'hff, 16'hffff, 16'h0001,
             1'b1, 8'h33, 16'h0000, 8'hfd);
    add_case(OP_ADD16, 8'h00, 8'h00, 8'h00, 16'h0fff, 16'h0001,
             1'b0, 8'h00, 16'h0000, 8'h00);
    // unused code passes acc and flags through, wide result stays zero
    add_case(OP_UNUSED_TOP, 8'ha5, 8'hff, 8'h3c, 16'hffff, 16'hffff,
             1'b1, 8'ha5, 16'h0000, 8'h3c);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      offer_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 125 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
      offer_item(random_item(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/ebalu_pkg.sv
design/ebalu_core.sv
design/eight_bit_alu_with_flags_unit.sv
tb/eight_bit_alu_with_flags_unit_tb.sv
